// ===== rtl/sitd_pkg.sv =====
`timescale 1ns / 1ps
// sitd_pkg: shared widths, character codes and types for the signed integer
// to decimal ascii converter. No dependencies.

package sitd_pkg;

   // widths of the value, its bcd image and the character
   localparam int VALUE_W    = 32;
   localparam int DIGITS     = 10;
   localparam int DIGIT_W    = 4;
   localparam int BCD_W      = DIGITS * DIGIT_W;
   localparam int CHAR_W     = 7;
   localparam int BIT_CNT_W  = 6;
   localparam int DIG_CNT_W  = 4;

   // ascii codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;

   // bcd digit correction threshold and offset for shift-add-3
   localparam logic [DIGIT_W-1:0] DABBLE_LIMIT  = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_OFFSET = 4'd3;

   // converted number handed from the bcd unit to the character sequencer
   typedef struct packed {
      logic             load;
      logic             negative;
      logic [BCD_W-1:0] bcd;
   } sitd_bcd_type;

   // shift-add-3 correction of one bcd digit
   function automatic logic [DIGIT_W-1:0] sitd_correct(input logic [DIGIT_W-1:0] digit);
      sitd_correct = (digit >= DABBLE_LIMIT) ? digit + DABBLE_OFFSET : digit;
   endfunction

endpackage

// ===== rtl/sitd_dabble.sv =====
`timescale 1ns / 1ps
// sitd_dabble: iterative binary to bcd unit, one shift-add-3 step per cycle.
// Depends on sitd_pkg.

module sitd_dabble
   import sitd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               negative,
   input  logic [VALUE_W-1:0] magnitude,
   output logic               busy,
   output sitd_bcd_type       result
);

   logic [VALUE_W-1:0]   bin_ff, bin_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [BCD_W-1:0]     corrected;

   // add 3 to every digit of 5 or more, all digits side by side
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         corrected[i*DIGIT_W +: DIGIT_W] = sitd_correct(bcd_ff[i*DIGIT_W +: DIGIT_W]);
      end
   end

   // load, then shift one binary bit into the bcd word per cycle
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in = magnitude;
         bcd_in = '0;
         cnt_in = BIT_CNT_W'(VALUE_W);
         run_in = 1'b1;
         neg_in = negative;
      end else if (run_ff) begin
         bcd_in = {corrected[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == BIT_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign busy            = run_ff | done_ff;
   assign result.load     = done_ff;
   assign result.negative = neg_ff;
   assign result.bcd      = bcd_ff;

endmodule

// ===== rtl/sitd_emit.sv =====
`timescale 1ns / 1ps
// sitd_emit: drops leading zero digits, then sends the sign and the digits
// through a registered output stage. Depends on sitd_pkg.

module sitd_emit
   import sitd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sitd_bcd_type      number,
   output logic              busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_ascii_char,
   output logic              rsp_is_last
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SKIP  = 2'd1;
   localparam logic [1:0] ST_SIGN  = 2'd2;
   localparam logic [1:0] ST_DIGIT = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [DIG_CNT_W-1:0] left_ff, left_in;
   logic                 neg_ff, neg_in;
   logic                 valid_ff, valid_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 last_ff, last_in;
   logic                 slot_free;
   logic [DIGIT_W-1:0]   top_digit;

   assign slot_free = ~valid_ff | rsp_ready;
   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];

   // character sequencer
   always_comb begin
      state_in = state_ff;
      bcd_in   = bcd_ff;
      left_in  = left_ff;
      neg_in   = neg_ff;
      valid_in = valid_ff & ~rsp_ready;
      char_in  = char_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (number.load) begin
               bcd_in   = number.bcd;
               neg_in   = number.negative;
               left_in  = DIG_CNT_W'(DIGITS);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // strip leading zeros, keeping at least one digit
            if (top_digit == '0 && left_ff > DIG_CNT_W'(1)) begin
               bcd_in  = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               left_in = left_ff - 1'b1;
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               valid_in = 1'b1;
               char_in  = CHAR_MINUS;
               last_in  = 1'b0;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (slot_free) begin
               valid_in = 1'b1;
               char_in  = CHAR_ZERO + CHAR_W'(top_digit);
               last_in  = (left_ff == DIG_CNT_W'(1));
               bcd_in   = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               left_in  = left_ff - 1'b1;
               if (left_ff == DIG_CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      bcd_ff  <= bcd_in;
      left_ff <= left_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_is_last    = last_ff;

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// signed_int_to_decimal_ascii: top level of the integer to decimal text block.
// Depends on sitd_pkg, sitd_dabble and sitd_emit.
//
// Usage:
//   A request on req_* carries one 32-bit two's complement integer. The block
//   answers with its decimal text on rsp_*, one ascii character per transfer,
//   most significant first: a '-' for negative values, then the digits with
//   no leading zeros ('0' alone for zero). rsp_is_last marks the final one.
//   Timing: after acceptance the shift-add-3 bcd unit converts one bit per
//   cycle, a registered hand-off passes the result to the sequencer, which
//   drops leading zeros (up to 9), then sends one character per cycle while
//   the receiver takes them. req_ready is low while the bcd unit runs or
//   characters remain to be sent, and rises again while the last character
//   may still wait in the output register.
//   A stalled receiver holds the current character in the output register;
//   the sequencer waits until it is taken.
//   Reset (synchronous, active high) drops any request in flight and clears
//   rsp_valid.

module signed_int_to_decimal_ascii
   import sitd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_signed_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [CHAR_W-1:0]         rsp_ascii_char,
   output logic                      rsp_is_last
);

   logic               dabble_busy;
   logic               emit_busy;
   logic               start;
   logic               negative;
   logic [VALUE_W-1:0] raw;
   logic [VALUE_W-1:0] magnitude;
   sitd_bcd_type       number;

   // magnitude as unsigned, so the most negative value comes out right
   assign raw       = $unsigned(req_signed_value);
   assign negative  = raw[VALUE_W-1];
   assign magnitude = negative ? ('0 - raw) : raw;

   assign req_ready = ~dabble_busy & ~emit_busy;
   assign start     = req_valid & req_ready;

   sitd_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .negative  (negative),
      .magnitude (magnitude),
      .busy      (dabble_busy),
      .result    (number)
   );

   sitd_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .number         (number),
      .busy           (emit_busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_is_last    (rsp_is_last)
   );

endmodule

// ===== rtl/sitd_checker.sv =====
`timescale 1ns / 1ps
// sitd_checker: port-level checks on the integer to decimal text block,
// bound to the top level. Depends on sitd_pkg.

module sitd_checker
   import sitd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAR_W-1:0] rsp_ascii_char,
   input logic              rsp_is_last
);

   // no response right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled response holds its character and flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ascii_char) && $stable(rsp_is_last))
      else $error("stalled response changed");

   // only a minus sign or a decimal digit is ever sent
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ascii_char == CHAR_MINUS) ||
                    (rsp_ascii_char >= CHAR_ZERO && rsp_ascii_char <= CHAR_NINE))
      else $error("illegal character");

   // the sign is never the last character
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ascii_char == CHAR_MINUS |-> !rsp_is_last)
      else $error("minus sign marked last");

   // a new request is not taken in the cycle after one is accepted
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("back to back request accepted");

endmodule

bind signed_int_to_decimal_ascii sitd_checker u_sitd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_ascii_char (rsp_ascii_char),
   .rsp_is_last    (rsp_is_last)
);
